/* rtl/cac_pkg.sv */
`timescale 1ns / 1ps
// cac_pkg: widths, payload structs and helpers for the circle/box contact pipeline
// depends on nothing; imported by every module of the block

package cac_pkg;

  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned RAD_W      = COORD_BITS - 1;
  localparam int unsigned NORM_W     = FRAC_BITS + 2;
  localparam int unsigned SQ_W       = 2 * RAD_W;
  localparam int unsigned ROOT_W     = RAD_W;
  localparam int unsigned REM_W      = ROOT_W + 3;
  localparam int unsigned DIFF_W     = COORD_BITS + 1;
  localparam int unsigned OFS_W      = COORD_BITS + 3;
  localparam int unsigned DD_W       = COORD_BITS + 5;
  localparam int unsigned QUO_W      = NORM_W;
  localparam int unsigned IN_W       = 7 * COORD_BITS - 1;
  localparam int unsigned IN_BYTES_W = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_W      = 1 + 2 * NORM_W + COORD_BITS;
  localparam int unsigned OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

  localparam logic signed [NORM_W-1:0] NORM_ONE = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_BITS-1:0] box_max_y;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic        [RAD_W-1:0]      radius;
    logic signed [COORD_BITS-1:0] circle_y;
    logic signed [COORD_BITS-1:0] circle_x;
  } cac_in_t;

  // per-item payload carried alongside the root and quotient pipelines
  typedef struct packed {
    logic                         ok;
    logic                         central;
    logic signed [NORM_W-1:0]     nx_c;
    logic signed [NORM_W-1:0]     ny_c;
    logic signed [COORD_BITS-1:0] depth_c;
    logic        [RAD_W-1:0]      radius;
    logic                         sx;
    logic                         sy;
    logic        [RAD_W-1:0]      ax;
    logic        [RAD_W-1:0]      ay;
  } cac_side_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] depth;
    logic signed [NORM_W-1:0]     normal_y;
    logic signed [NORM_W-1:0]     normal_x;
    logic                         overlap;
  } cac_res_t;

  // saturate a wide signed value to the coordinate range
  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [DD_W-1:0] v
  );
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[DD_W-1:COORD_BITS-1];
    hi_zeros = ~|v[DD_W-1:COORD_BITS-1];
    if (hi_ones || hi_zeros) begin
      return v[COORD_BITS-1:0];
    end else if (v[DD_W-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

endpackage

/* rtl/cac_front.sv */
`timescale 1ns / 1ps
// cac_front: clamp, squares, squared-distance sum and overlap / central tests (4 stages)
// depends on cac_pkg

module cac_front import cac_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cac_in_t               in_i,
  input  logic [THR_W-1:0]      thr_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cac_side_t             side_o,
  output logic [SQ_W-1:0]       d2_o
);

  logic adv1, adv2, adv3, adv4;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1: clamp and offsets
  logic signed [COORD_BITS-1:0] cx, cy, mnx, mny, mxx, mxy, clx, cly;
  logic signed [DIFF_W-1:0]     dx_d, dy_d, w_d, h_d;
  logic        [DIFF_W-1:0]     adx_d, ady_d;
  logic signed [OFS_W-1:0]      ox_d, oy_d;
  logic                         rej_d;

  logic                         rej1_q;
  logic        [RAD_W-1:0]      ax1_q, ay1_q, rad1_q;
  logic                         sx1_q, sy1_q;
  logic signed [OFS_W-1:0]      ox1_q, oy1_q;
  logic signed [DIFF_W-1:0]     w1_q, h1_q;

  always_comb begin
    cx  = in_i.circle_x;
    cy  = in_i.circle_y;
    mnx = in_i.box_min_x;
    mny = in_i.box_min_y;
    mxx = in_i.box_max_x;
    mxy = in_i.box_max_y;
    if (cx < mnx) begin
      clx = mnx;
    end else if (cx > mxx) begin
      clx = mxx;
    end else begin
      clx = cx;
    end
    if (cy < mny) begin
      cly = mny;
    end else if (cy > mxy) begin
      cly = mxy;
    end else begin
      cly = cy;
    end
    dx_d  = DIFF_W'(cx) - DIFF_W'(clx);
    dy_d  = DIFF_W'(cy) - DIFF_W'(cly);
    adx_d = dx_d[DIFF_W-1] ? DIFF_W'(-dx_d) : DIFF_W'(dx_d);
    ady_d = dy_d[DIFF_W-1] ? DIFF_W'(-dy_d) : DIFF_W'(dy_d);
    rej_d = (adx_d > DIFF_W'(in_i.radius)) || (ady_d > DIFF_W'(in_i.radius));
    ox_d  = (OFS_W'(cx) <<< 1) - OFS_W'(mnx) - OFS_W'(mxx);
    oy_d  = (OFS_W'(cy) <<< 1) - OFS_W'(mny) - OFS_W'(mxy);
    w_d   = DIFF_W'(mxx) - DIFF_W'(mnx);
    h_d   = DIFF_W'(mxy) - DIFF_W'(mny);
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      rej1_q <= rej_d;
      ax1_q  <= adx_d[RAD_W-1:0];
      ay1_q  <= ady_d[RAD_W-1:0];
      sx1_q  <= dx_d[DIFF_W-1];
      sy1_q  <= dy_d[DIFF_W-1];
      rad1_q <= in_i.radius;
      ox1_q  <= ox_d;
      oy1_q  <= oy_d;
      w1_q   <= w_d;
      h1_q   <= h_d;
    end
  end

  // stage 2: squares and central-case depth
  logic        [SQ_W-1:0]       sqx_d, sqy_d, rr_d;
  logic        [2*THR_W-1:0]    tt_d;
  logic                         xsel;
  logic        [OFS_W-1:0]      aox, aoy;
  logic signed [DD_W-1:0]       dd_d, half_d;
  cac_side_t                    side2_d;

  logic                         rej2_q;
  logic        [SQ_W-1:0]       sqx2_q, sqy2_q, rr2_q;
  logic        [2*THR_W-1:0]    tt2_q;
  cac_side_t                    side2_q;

  always_comb begin
    sqx_d  = SQ_W'(ax1_q) * SQ_W'(ax1_q);
    sqy_d  = SQ_W'(ay1_q) * SQ_W'(ay1_q);
    rr_d   = SQ_W'(rad1_q) * SQ_W'(rad1_q);
    tt_d   = (2*THR_W)'(thr_i) * (2*THR_W)'(thr_i);
    // ties between half-extents take the y axis
    xsel   = w1_q < h1_q;
    aox    = ox1_q[OFS_W-1] ? OFS_W'(-ox1_q) : OFS_W'(ox1_q);
    aoy    = oy1_q[OFS_W-1] ? OFS_W'(-oy1_q) : OFS_W'(oy1_q);
    dd_d   = (DD_W'({1'b0, rad1_q}) <<< 1)
           + (xsel ? DD_W'(w1_q) : DD_W'(h1_q))
           - DD_W'(xsel ? aox : aoy);
    half_d = dd_d >>> 1;
    side2_d         = '0;
    side2_d.nx_c    = xsel ? (ox1_q[OFS_W-1] ? -NORM_ONE : NORM_ONE) : '0;
    side2_d.ny_c    = xsel ? '0 : (oy1_q[OFS_W-1] ? -NORM_ONE : NORM_ONE);
    side2_d.depth_c = sat_coord(half_d);
    side2_d.radius  = rad1_q;
    side2_d.sx      = sx1_q;
    side2_d.sy      = sy1_q;
    side2_d.ax      = ax1_q;
    side2_d.ay      = ay1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      rej2_q  <= rej1_q;
      sqx2_q  <= sqx_d;
      sqy2_q  <= sqy_d;
      rr2_q   <= rr_d;
      tt2_q   <= tt_d;
      side2_q <= side2_d;
    end
  end

  // stage 3: squared distance
  logic                         rej3_q;
  logic        [SQ_W:0]         d23_q;
  logic        [SQ_W-1:0]       rr3_q;
  logic        [2*THR_W-1:0]    tt3_q;
  cac_side_t                    side3_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      rej3_q  <= rej2_q;
      d23_q   <= {1'b0, sqx2_q} + {1'b0, sqy2_q};
      rr3_q   <= rr2_q;
      tt3_q   <= tt2_q;
      side3_q <= side2_q;
    end
  end

  // stage 4: overlap and central tests
  cac_side_t                    side4_d;
  cac_side_t                    side4_q;
  logic        [SQ_W-1:0]       d24_q;

  always_comb begin
    side4_d         = side3_q;
    side4_d.ok      = !rej3_q && (d23_q <= {1'b0, rr3_q});
    side4_d.central = d23_q <= (SQ_W+1)'(tt3_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      side4_q <= side4_d;
      d24_q   <= d23_q[SQ_W-1:0];
    end
  end

  // valid bits and ripple ready
  assign adv4 = !v4_q || out_ready_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  assign in_ready_o  = adv1;
  assign out_valid_o = v4_q;
  assign side_o      = side4_q;
  assign d2_o        = d24_q;

endmodule

/* rtl/cac_sqrt.sv */
`timescale 1ns / 1ps
// cac_sqrt: pipelined digit-by-digit integer square root, one root bit per stage
// depends on cac_pkg

module cac_sqrt import cac_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cac_side_t         side_i,
  input  logic [SQ_W-1:0]   rad_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cac_side_t         side_o,
  output logic [ROOT_W-1:0] root_o
);

  logic              v_q    [ROOT_W];
  cac_side_t         side_q [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SQ_W-1:0]   rest_q [ROOT_W];
  logic              adv    [ROOT_W+1];

  assign adv[ROOT_W] = out_ready_i;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              pv;
    cac_side_t         pside;
    logic [REM_W-1:0]  prem;
    logic [ROOT_W-1:0] proot;
    logic [SQ_W-1:0]   prest;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign pv    = in_valid_i;
      assign pside = side_i;
      assign prem  = '0;
      assign proot = '0;
      assign prest = rad_i;
    end else begin : g_next
      assign pv    = v_q[k-1];
      assign pside = side_q[k-1];
      assign prem  = rem_q[k-1];
      assign proot = root_q[k-1];
      assign prest = rest_q[k-1];
    end

    always_comb begin
      rem_sh = {prem[REM_W-3:0], prest[SQ_W-1 -: 2]};
      trial  = REM_W'({proot, 2'b01});
      ge     = rem_sh >= trial;
    end

    assign adv[k] = !v_q[k] || adv[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv[k]) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        side_q[k] <= pside;
        rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k] <= {proot[ROOT_W-2:0], ge};
        rest_q[k] <= {prest[SQ_W-3:0], 2'b00};
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[ROOT_W-1];
  assign side_o      = side_q[ROOT_W-1];
  assign root_o      = root_q[ROOT_W-1];

endmodule

/* rtl/cac_div.sv */
`timescale 1ns / 1ps
// cac_div: two-lane restoring divider for the unit normal, rounding and result select
// depends on cac_pkg; its last stage is the output register of the block

module cac_div import cac_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cac_side_t         side_i,
  input  logic [ROOT_W-1:0] root_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cac_res_t          res_o
);

  localparam int unsigned NS = FRAC_BITS + 1;

  logic              v_q    [NS];
  cac_side_t         side_q [NS];
  logic [ROOT_W-1:0] dist_q [NS];
  logic [QUO_W-1:0]  qx_q   [NS];
  logic [QUO_W-1:0]  qy_q   [NS];
  logic [ROOT_W-1:0] rx_q   [NS];
  logic [ROOT_W-1:0] ry_q   [NS];
  logic              adv    [NS+1];

  logic              out_v_q;
  cac_res_t          res_q;

  // stage 0: distance floor of one, integer quotient bit
  logic [ROOT_W-1:0] dist0_d;
  logic              qx0_d, qy0_d;

  always_comb begin
    dist0_d = (root_i == '0) ? ROOT_W'(1) : root_i;
    qx0_d   = side_i.ax >= dist0_d;
    qy0_d   = side_i.ay >= dist0_d;
  end

  assign adv[0] = !v_q[0] || adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv[0]) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      side_q[0] <= side_i;
      dist_q[0] <= dist0_d;
      qx_q[0]   <= QUO_W'(qx0_d);
      qy_q[0]   <= QUO_W'(qy0_d);
      rx_q[0]   <= side_i.ax - (qx0_d ? dist0_d : '0);
      ry_q[0]   <= side_i.ay - (qy0_d ? dist0_d : '0);
    end
  end

  // stages 1..FRAC_BITS: one fraction bit per lane
  for (genvar k = 1; k < NS; k++) begin : g_step
    logic [ROOT_W:0] rxs, rys, dext;
    logic            gex, gey;

    always_comb begin
      rxs  = {rx_q[k-1], 1'b0};
      rys  = {ry_q[k-1], 1'b0};
      dext = {1'b0, dist_q[k-1]};
      gex  = rxs >= dext;
      gey  = rys >= dext;
    end

    assign adv[k] = !v_q[k] || adv[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv[k]) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        side_q[k] <= side_q[k-1];
        dist_q[k] <= dist_q[k-1];
        qx_q[k]   <= {qx_q[k-1][QUO_W-2:0], gex};
        qy_q[k]   <= {qy_q[k-1][QUO_W-2:0], gey};
        rx_q[k]   <= gex ? ROOT_W'(rxs - dext) : rxs[ROOT_W-1:0];
        ry_q[k]   <= gey ? ROOT_W'(rys - dext) : rys[ROOT_W-1:0];
      end
    end
  end

  // last stage: round half up, apply sign, pick central or radial result
  cac_side_t                    sl;
  logic [ROOT_W-1:0]            dl;
  logic [QUO_W-1:0]             qxr, qyr;
  logic signed [NORM_W-1:0]     nx_d, ny_d;
  logic signed [COORD_BITS-1:0] dep_d;
  cac_res_t                     res_d;

  always_comb begin
    sl    = side_q[NS-1];
    dl    = dist_q[NS-1];
    qxr   = qx_q[NS-1] + QUO_W'({rx_q[NS-1], 1'b0} >= {1'b0, dl});
    qyr   = qy_q[NS-1] + QUO_W'({ry_q[NS-1], 1'b0} >= {1'b0, dl});
    nx_d  = sl.sx ? -signed'(qxr) : signed'(qxr);
    ny_d  = sl.sy ? -signed'(qyr) : signed'(qyr);
    dep_d = signed'({1'b0, sl.radius}) - signed'(COORD_BITS'(dl));
    res_d = '0;
    if (sl.ok) begin
      res_d.overlap = 1'b1;
      if (sl.central) begin
        res_d.normal_x = sl.nx_c;
        res_d.normal_y = sl.ny_c;
        res_d.depth    = sl.depth_c;
      end else begin
        res_d.normal_x = nx_d;
        res_d.normal_y = ny_d;
        res_d.depth    = dep_d;
      end
    end
  end

  assign adv[NS] = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv[NS]) begin
      out_v_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NS]) begin
      res_q <= res_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = out_v_q;
  assign res_o       = res_q;

endmodule

/* rtl/circle_aabb_contact.sv */
`timescale 1ns / 1ps
// circle_aabb_contact: top level of the circle / axis-aligned box contact pipeline
// depends on cac_pkg, cac_front, cac_sqrt and cac_div
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+-------------------------------------
//  s_axis    | in  | tvalid / tready              | circle, radius, box corners (224 b)
//  m_axis    | out | tvalid / tready              | overlap, normal_x/y, depth (72 b)
//  cfg       | in  | cfg_we_i, no wait            | center_threshold (16 b)
//
//  one request is taken per cycle while m_axis does not stall; each result passes through
//  4 front stages, 31 square-root stages, 17 divider stages and 1 output register
//  the depth is set by the square root, which resolves one root bit per stage
//  every stage has its own valid bit and a ripple ready, so bubbles close up and
//  a stall at m_axis neither drops nor repeats a request
//  reset clears the valid bits and the threshold; payload registers are not reset

module circle_aabb_contact import cac_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // lsb first: circle_x, circle_y, radius, box_min_x, box_min_y, box_max_x,
  // box_max_y, zero pad
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_BYTES_W-1:0]  s_axis_tdata,
  // lsb first: overlap, normal_x, normal_y, depth, zero pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_BYTES_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [THR_W-1:0]       cfg_wdata_i
);

  // separation threshold, to be written only while the pipeline is empty; the block does not enforce this
  logic [THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  cac_in_t in_req;
  assign in_req = cac_in_t'(s_axis_tdata[IN_W-1:0]);

  // front: clamp, squares, overlap and central tests
  logic             fr_valid, fr_ready;
  cac_side_t        fr_side;
  logic [SQ_W-1:0]  fr_d2;

  cac_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_i        (in_req),
    .thr_i       (thr_q),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .side_o      (fr_side),
    .d2_o        (fr_d2)
  );

  // distance as floor of the root of the squared distance
  logic              sq_valid, sq_ready;
  cac_side_t         sq_side;
  logic [ROOT_W-1:0] sq_root;

  cac_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .side_i      (fr_side),
    .rad_i       (fr_d2),
    .out_valid_o (sq_valid),
    .out_ready_i (sq_ready),
    .side_o      (sq_side),
    .root_o      (sq_root)
  );

  // normal components and final result select
  cac_res_t res;

  cac_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_valid),
    .in_ready_o  (sq_ready),
    .side_i      (sq_side),
    .root_i      (sq_root),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = OUT_BYTES_W'(res);

  // no contact means an all-zero normal and depth
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.overlap |->
      res.normal_x == '0 && res.normal_y == '0 && res.depth == '0)
    else $error("miss carries a non-zero normal or depth");

  // each normal component stays within plus or minus one
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      res.normal_x <= NORM_ONE && res.normal_x >= -NORM_ONE &&
      res.normal_y <= NORM_ONE && res.normal_y >= -NORM_ONE)
    else $error("normal component out of range");

  // an empty output register lets the whole pipeline move
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

endmodule

/* test/tb_circle_aabb_contact.sv */
`timescale 1ns / 1ps
// tb_circle_aabb_contact: self-checking bench for the circle / box contact pipeline
// depends on cac_pkg and circle_aabb_contact; directed table, then random pairs

module tb_circle_aabb_contact;
  import cac_pkg::*;

  localparam longint ONE        = 64'sd65536;
  localparam int     LATENCY    = 60;     // drain wait, longer than the pipeline is deep
  localparam int     WD_LIMIT   = 20000;  // cycles with no request moving on either side
  localparam int     HOLD_LEN   = 400;    // long receiver hold-off, fills the pipeline
  localparam int     N_CHUNK    = 250;

  typedef enum int {IDLE_TX_LIGHT, IDLE_RX_LIGHT, IDLE_NONE} idle_mode_e;

  typedef struct {
    cac_in_t    req;
    logic [15:0] thr;
    bit         typed;
    cac_res_t   res;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_BYTES_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_BYTES_W-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic [THR_W-1:0]       cfg_wdata_i = '0;

  cac_res_t    contact_q[$];  // expected contacts, oldest first
  logic [15:0] thr_model = '0;
  idle_mode_e  idle_mode = IDLE_TX_LIGHT;
  bit          hold_req = 1'b0;
  int          n_errors = 0;
  int          hold_cnt = 0;
  int          quiet_cnt = 0;
  dir_row_t    dir_rows[$];

  always #4 clk_i = ~clk_i;

  circle_aabb_contact i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // floor square root of the squared distance, one root bit at a time
  function automatic longint unsigned root_floor(logic [127:0] v);
    logic [127:0] acc;
    logic [127:0] cand;
    acc = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = acc | (128'd1 << b);
      if (cand * cand <= v) acc = cand;
    end
    return acc[63:0];
  endfunction

  // |d| / dlen in Q.FRAC, rounded half away from zero, sign of d
  function automatic longint unit_part(longint d, longint dlen);
    longint a;
    longint q;
    longint rem;
    a   = (d < 0) ? -d : d;
    q   = (a >= dlen) ? 1 : 0;
    rem = a - q * dlen;
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= dlen) begin
        rem = rem - dlen;
        q   = q | 1;
      end
    end
    if (2 * rem >= dlen) q++;
    return (d < 0) ? -q : q;
  endfunction

  function automatic cac_res_t predict_contact(cac_in_t p, logic [15:0] thr);
    longint cx, cy, mnx, mny, mxx, mxy, r, kx, ky, dx, dy, ax, ay;
    longint ox2, oy2, w2, h2, dd, dep, nx, ny;
    longint unsigned dlen;
    logic [127:0] wa, wb, wr, d2, t2;
    cac_res_t res;
    res = '0;
    cx  = p.circle_x;
    cy  = p.circle_y;
    r   = p.radius;
    mnx = p.box_min_x;
    mny = p.box_min_y;
    mxx = p.box_max_x;
    mxy = p.box_max_y;
    // min bound is tested first, so an inverted box clamps to min when below it
    kx = (cx < mnx) ? mnx : ((cx > mxx) ? mxx : cx);
    ky = (cy < mny) ? mny : ((cy > mxy) ? mxy : cy);
    dx = cx - kx;
    dy = cy - ky;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax > r || ay > r) return res;
    wa = ax;
    wb = ay;
    wr = r;
    d2 = wa * wa + wb * wb;
    if (d2 > wr * wr) return res;
    t2 = 128'(thr) * 128'(thr);
    nx = 0;
    ny = 0;
    if (d2 <= t2) begin
      // central case, doubled box centre and half-extents; ties go to y
      ox2 = 2 * cx - mnx - mxx;
      oy2 = 2 * cy - mny - mxy;
      w2  = mxx - mnx;
      h2  = mxy - mny;
      if (w2 < h2) begin
        nx = (ox2 < 0) ? -ONE : ONE;
        dd = 2 * r + w2 - ((ox2 < 0) ? -ox2 : ox2);
      end else begin
        ny = (oy2 < 0) ? -ONE : ONE;
        dd = 2 * r + h2 - ((oy2 < 0) ? -oy2 : oy2);
      end
      dep = dd >>> 1;
    end else begin
      dlen = root_floor(d2);
      if (dlen == 0) dlen = 1;
      nx  = unit_part(dx, longint'(dlen));
      ny  = unit_part(dy, longint'(dlen));
      dep = r - longint'(dlen);
    end
    if (dep > 64'sd2147483647) dep = 64'sd2147483647;
    if (dep < -64'sd2147483648) dep = -64'sd2147483648;
    res.overlap  = 1'b1;
    res.normal_x = nx[NORM_W-1:0];
    res.normal_y = ny[NORM_W-1:0];
    res.depth    = dep[COORD_BITS-1:0];
    return res;
  endfunction

  function automatic cac_in_t mk_pair(longint cx, longint cy, longint r, longint mnx,
                                      longint mny, longint mxx, longint mxy);
    cac_in_t p;
    p.circle_x  = cx[31:0];
    p.circle_y  = cy[31:0];
    p.radius    = r[30:0];
    p.box_min_x = mnx[31:0];
    p.box_min_y = mny[31:0];
    p.box_max_x = mxx[31:0];
    p.box_max_y = mxy[31:0];
    return p;
  endfunction

  function automatic cac_res_t mk_res(logic ov, longint nx, longint ny, longint dep);
    cac_res_t c;
    c.overlap  = ov;
    c.normal_x = nx[NORM_W-1:0];
    c.normal_y = ny[NORM_W-1:0];
    c.depth    = dep[31:0];
    return c;
  endfunction

  function automatic longint srand(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  // mostly boxes with a circle near them, some fully random words
  function automatic cac_in_t random_pair();
    cac_in_t p;
    longint bx, by, w, h, cx, cy, r, t;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      p = cac_in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom}));
      if ($urandom_range(0, 1)) p.radius[30:26] = '0;
      return p;
    end
    bx = srand(64'd1 << 28);
    by = srand(64'd1 << 28);
    w  = $urandom_range(0, 1 << $urandom_range(2, 22));
    h  = ($urandom_range(0, 3) == 0) ? w : $urandom_range(0, 1 << $urandom_range(2, 22));
    cx = bx + srand(w + (64'd1 << $urandom_range(2, 23)));
    cy = by + srand(h + (64'd1 << $urandom_range(2, 23)));
    r  = $urandom_range(0, 1 << $urandom_range(1, 24));
    if (kind == 1) r = $urandom_range(0, 32'h7fff_ffff);
    if (kind == 2) begin
      cx = bx;
      cy = by;
    end
    p = mk_pair(cx, cy, r, bx - w, by - h, bx + w, by + h);
    if (kind == 3) begin
      t = p.box_min_x;
      p.box_min_x = p.box_max_x;
      p.box_max_x = t[31:0];
    end
    return p;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    n_errors++;
  endtask

  // offer one request, with idle cycles before it as the idle mode asks
  task automatic send_pair(cac_in_t p, bit typed, cac_res_t want);
    int idle_pct;
    idle_pct = (idle_mode == IDLE_TX_LIGHT) ? 29 : ((idle_mode == IDLE_RX_LIGHT) ? 64 : 0);
    if ($urandom_range(1, 100) <= idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(1, 100) <= idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, p};
    do @(posedge clk_i); while (!s_axis_tready);
    contact_q.push_back(typed ? want : predict_contact(p, thr_model));
  endtask

  // only while idle: all contacts out, then the pipeline latency
  task automatic write_threshold(logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    thr_model   = v;
  endtask

  // receiver: random stalls, long hold-off on request, checking and watchdog
  always @(posedge clk_i) begin
    cac_res_t got;
    cac_res_t want;
    int idle_pct;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OUT_W-1:0];
        if (contact_q.size() == 0) begin
          report("unexpected contact", got.overlap, 0);
        end else begin
          want = contact_q.pop_front();
          if (got.overlap !== want.overlap) report("overlap", got.overlap, want.overlap);
          if (got.normal_x !== want.normal_x) report("normal_x", got.normal_x, want.normal_x);
          if (got.normal_y !== want.normal_y) report("normal_y", got.normal_y, want.normal_y);
          if (got.depth !== want.depth) report("depth", got.depth, want.depth);
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cnt = 0;
      end else begin
        quiet_cnt++;
        if (quiet_cnt >= WD_LIMIT) begin
          $display("watchdog: no request moved for %0d cycles", WD_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
    if (hold_req && hold_cnt == 0) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_LEN;
    end
    idle_pct = (idle_mode == IDLE_TX_LIGHT) ? 64 : ((idle_mode == IDLE_RX_LIGHT) ? 29 : 0);
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(1, 100) > idle_pct);
    end
  end

  initial begin
    logic [15:0] thr_plan[5];
    idle_mode_e  mode_plan[5];
    // directed table: typed rows can be read off directly, the rest are predicted
    dir_rows.push_back('{mk_pair(0, 0, ONE, -2*ONE, -ONE, 2*ONE, ONE), 16'd0, 1,
                         mk_res(1, 0, ONE, 2*ONE)});
    dir_rows.push_back('{mk_pair(100*ONE, 0, ONE, 0, 0, ONE, ONE), 16'd0, 1,
                         mk_res(0, 0, 0, 0)});
    dir_rows.push_back('{mk_pair(0, 0, 0, 0, 0, 0, 0), 16'd0, 1, mk_res(1, 0, ONE, 0)});
    // touching exactly at the radius, outside the threshold
    dir_rows.push_back('{mk_pair(3*ONE, 0, ONE, 0, -ONE, 2*ONE, ONE), 16'd0, 1,
                         mk_res(1, ONE, 0, 0)});
    // narrower box, negative offset: normal along minus x
    dir_rows.push_back('{mk_pair(-ONE/2, 0, ONE, -ONE, -4*ONE, ONE, 4*ONE), 16'd0, 1,
                         mk_res(1, -ONE, 0, 98304)});
    dir_rows.push_back('{mk_pair(-2147483648, -2147483648, 0, -2147483648, -2147483648,
                         -2147483648, -2147483648), 16'd0, 0, '0});
    dir_rows.push_back('{mk_pair(2147483647, 2147483647, 2147483647, 2147483647,
                         2147483647, 2147483647, 2147483647), 16'd0, 0, '0});
    dir_rows.push_back('{mk_pair(-2147483648, 0, 2147483647, 2147483647, 0,
                         2147483647, 0), 16'd0, 0, '0});
    // huge box: central depth saturates high
    dir_rows.push_back('{mk_pair(0, 0, 2147483647, -2147483648, -2147483648,
                         2147483647, 2147483647), 16'd0, 0, '0});
    // inverted boxes, negative half-extents
    dir_rows.push_back('{mk_pair(0, 0, ONE, ONE, ONE, -ONE, -ONE), 16'd0, 0, '0});
    dir_rows.push_back('{mk_pair(-2147483648, -2147483648, 0, -2147483648, -2147483648,
                         -2147483648+1, -2147483648+1), 16'd0, 0, '0});
    dir_rows.push_back('{mk_pair(2147483647, 2147483647, 0, 2147483647, 2147483647,
                         -2147483648, -2147483648), 16'd0, 0, '0});
    dir_rows.push_back('{mk_pair(3*ONE, 3*ONE, 2*ONE, 0, 0, 2*ONE, 2*ONE), 16'd0, 0, '0});
    dir_rows.push_back('{mk_pair(-ONE, -ONE, 2*ONE, 0, 0, ONE, ONE), 16'd0, 0, '0});
    dir_rows.push_back('{mk_pair(3*ONE, 0, 0, 0, 0, 2*ONE, ONE), 16'd0, 1,
                         mk_res(0, 0, 0, 0)});
    dir_rows.push_back('{mk_pair(3*ONE+1, 0, ONE, 0, -ONE, 2*ONE, ONE), 16'd0, 1,
                         mk_res(0, 0, 0, 0)});
    dir_rows.push_back('{mk_pair(ONE+1, ONE, 1, 0, 0, ONE, ONE), 16'd0, 0, '0});
    // squared distance equal to threshold squared takes the central case
    dir_rows.push_back('{mk_pair(2*ONE+16384, 0, ONE, 0, -ONE, 2*ONE, ONE), 16'h4000, 0,
                         '0});
    dir_rows.push_back('{mk_pair(2*ONE+16385, 0, ONE, 0, -ONE, 2*ONE, ONE), 16'h4000, 0,
                         '0});
    dir_rows.push_back('{mk_pair(ONE/2, 2*ONE+100, 3*ONE, 0, 0, ONE, 2*ONE), 16'hffff, 0,
                         '0});

    thr_plan  = '{16'hffff, 16'h0100, 16'h0000, 16'h8000, 16'h0001};
    mode_plan = '{IDLE_TX_LIGHT, IDLE_RX_LIGHT, IDLE_NONE, IDLE_TX_LIGHT, IDLE_NONE};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].thr != thr_model) write_threshold(dir_rows[i].thr);
      send_pair(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int c = 0; c < 5; c++) begin
      write_threshold((c == 3) ? 16'($urandom) : thr_plan[c]);
      idle_mode = mode_plan[c];
      if (c == 0 || c == 2) hold_req = 1'b1;  // stall the output while requests keep coming
      for (int n = 0; n < N_CHUNK; n++) send_pair(random_pair(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (contact_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    if (n_errors == 0 && contact_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
